[rtl/swmma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swmma_pkg;

    // Fixed widths of the request, response and register fields
    localparam int FIELD_W = 31;
    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    // Window size after reset
    localparam int WINDOW_RESET = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_POST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] sample;
        logic [POS_W-1:0]   read_position;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] latest;
        logic [FIELD_W-1:0] average;
        logic [FIELD_W-1:0] maximum;
        logic [FIELD_W-1:0] minimum;
        logic [COUNT_W-1:0] held_count;
        logic [FIELD_W-1:0] read_value;
        logic               read_valid;
    } t_rsp;

    typedef logic [CFG_W-1:0] t_cfg;

endpackage

`default_nettype wire

[rtl/swmma_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface swmma_req_if;
    logic             valid;
    logic             ready;
    swmma_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swmma_rsp_if;
    logic             valid;
    logic             ready;
    swmma_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swmma_cfg_if;
    logic             valid;
    logic             ready;
    swmma_pkg::t_cfg  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/sliding_window_min_max_average.sv]
// Sliding window statistics over duration samples.
//
// Channels: i_req carries one request (push, read by position, clear, or a
// no-op status query); o_rsp returns exactly one response per request with
// latest, average, maximum, minimum, held_count and the read result. i_cfg
// writes the window size (0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX)
// and clears the window; write it only while no request is in flight.
//
// Sequencing: one request at a time. A push rescans the held entries through
// the single read port of the sample memory, one entry per cycle, and once the
// window is full runs a radix-2 shift/subtract divider for the mean, one
// quotient bit per cycle (SUM_W = sample bits + count bits, 38 by default).
//   push while filling : scan, then emit
//   push when full     : scan, divide, post, emit
//   read               : divide (forms the slot), post, emit; emit only when empty
//   clear / no-op      : emit
// The response sits in an output register; i_req is ready again as soon as
// it is loaded, so a stalled receiver only holds the next request at emit.
// Reset (synchronous, active low) empties the window, zeroes all statistics
// and sets the window size to 16. The memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_max_average #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 31
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    swmma_cfg_if.sink        i_cfg,
    swmma_req_if.sink        i_req,
    swmma_rsp_if.source      o_rsp
);

    localparam int SW      = (SAMPLE_BITS < swmma_pkg::FIELD_W) ?
                             SAMPLE_BITS : swmma_pkg::FIELD_W;
    localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = SW + CNT_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int EFF_RST = (swmma_pkg::WINDOW_RESET > WINDOW_MAX) ?
                             WINDOW_MAX : swmma_pkg::WINDOW_RESET;

    // Sample memory, one write and one registered read per cycle
    logic [SW-1:0]        r_mem [WINDOW_MAX];
    logic [SW-1:0]        r_rd_data;

    swmma_pkg::t_state    r_state, n_state;

    // Window state
    logic [CNT_W-1:0]     r_eff;
    logic [CNT_W-1:0]     r_fill;
    logic [IDX_W-1:0]     r_optr;
    logic [SW-1:0]        r_latest;
    logic [SW-1:0]        r_mean;
    logic [SW-1:0]        r_max;
    logic [SW-1:0]        r_min;

    // Sequencer working registers
    logic [CNT_W-1:0]     r_idx;
    logic                 r_pend;
    logic                 r_first;
    logic                 r_do_mean;
    logic                 r_is_read;
    logic                 r_rd_ok;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [STEP_W-1:0]    r_step;

    swmma_pkg::t_rsp      r_out;
    logic                 r_out_valid;

    logic                 req_acc;
    logic                 cfg_acc;
    logic                 full;
    logic                 scan_issue;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic                 load_out;
    logic [CNT_W-1:0]     cfg_eff;
    logic [IDX_W-1:0]     optr_next;
    logic [CNT_W:0]       div_t;
    logic                 div_ge;
    logic [CNT_W-1:0]     div_rem;
    logic [SW-1:0]        req_sample;

    // No writes taken while reset is held
    assign i_cfg.ready = i_rst_n;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign req_sample  = i_req.data.sample[SW-1:0];

    assign full        = (r_fill >= r_eff);
    assign wr_addr     = full ? r_optr : r_fill[IDX_W-1:0];
    assign optr_next   = ((CNT_W'(r_optr) + 1'b1) == r_eff) ? '0 : r_optr + 1'b1;
    assign scan_issue  = (r_idx < r_fill);

    // Size register clamp: zero acts as one, oversize acts as WINDOW_MAX
    always_comb begin
        if (i_cfg.data == '0) begin
            cfg_eff = CNT_W'(1);
        end else if (int'(i_cfg.data) > WINDOW_MAX) begin
            cfg_eff = CNT_W'(WINDOW_MAX);
        end else begin
            cfg_eff = CNT_W'(i_cfg.data);
        end
    end

    // One restoring divide step
    assign div_t   = {r_rem, r_quo[SUM_W-1]};
    assign div_ge  = (div_t >= {1'b0, r_div});
    assign div_rem = div_ge ? CNT_W'(div_t - {1'b0, r_div}) : div_t[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (req_acc && (i_req.data.op == swmma_pkg::OP_PUSH)) begin
            r_mem[wr_addr] <= req_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmma_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IDX_W-1:0];
        load_out    = 1'b0;
        unique case (r_state)
            swmma_pkg::ST_IDLE: begin
                i_req.ready = i_rst_n;
                if (i_req.valid) begin
                    unique case (i_req.data.op)
                        swmma_pkg::OP_PUSH: n_state = swmma_pkg::ST_SCAN;
                        swmma_pkg::OP_READ: begin
                            n_state = (r_fill == '0) ? swmma_pkg::ST_EMIT
                                                     : swmma_pkg::ST_DIV;
                        end
                        default: n_state = swmma_pkg::ST_EMIT;
                    endcase
                end
            end
            swmma_pkg::ST_SCAN: begin
                rd_en = scan_issue;
                if (!scan_issue && !r_pend) begin
                    n_state = r_do_mean ? swmma_pkg::ST_DIV : swmma_pkg::ST_EMIT;
                end
            end
            swmma_pkg::ST_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = swmma_pkg::ST_POST;
                end
            end
            swmma_pkg::ST_POST: begin
                // Read op: remainder is the physical slot
                rd_en   = r_is_read;
                rd_addr = r_rem[IDX_W-1:0];
                n_state = swmma_pkg::ST_EMIT;
            end
            swmma_pkg::ST_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = swmma_pkg::ST_IDLE;
                end
            end
            default: n_state = swmma_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff       <= CNT_W'(EFF_RST);
            r_fill      <= '0;
            r_optr      <= '0;
            r_latest    <= '0;
            r_mean      <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_eff    <= cfg_eff;
                r_fill   <= '0;
                r_optr   <= '0;
                r_latest <= '0;
                r_mean   <= '0;
                r_max    <= '0;
                r_min    <= '0;
            end

            unique case (r_state)
                swmma_pkg::ST_IDLE: begin
                    if (req_acc) begin
                        r_is_read <= (i_req.data.op == swmma_pkg::OP_READ);
                        r_rd_ok   <= (r_fill != '0);
                        r_idx     <= '0;
                        r_pend    <= 1'b0;
                        r_first   <= 1'b1;
                        r_sum     <= '0;
                        r_rem     <= '0;
                        r_step    <= '0;
                        r_div     <= r_fill;
                        r_quo     <= SUM_W'(r_optr) + SUM_W'(i_req.data.read_position);
                        unique case (i_req.data.op)
                            swmma_pkg::OP_PUSH: begin
                                r_latest  <= req_sample;
                                r_do_mean <= full;
                                if (full) begin
                                    r_optr <= optr_next;
                                end else begin
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                            swmma_pkg::OP_CLEAR: begin
                                r_fill   <= '0;
                                r_optr   <= '0;
                                r_latest <= '0;
                                r_mean   <= '0;
                                r_max    <= '0;
                                r_min    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                swmma_pkg::ST_SCAN: begin
                    if (scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_pend <= scan_issue;
                    if (r_pend) begin
                        r_first <= 1'b0;
                        r_sum   <= r_sum + SUM_W'(r_rd_data);
                        if (r_first || (r_rd_data > r_max)) begin
                            r_max <= r_rd_data;
                        end
                        if (r_first || (r_rd_data < r_min)) begin
                            r_min <= r_rd_data;
                        end
                    end
                    if (!scan_issue && !r_pend) begin
                        // Window was full: sum covers exactly r_eff entries
                        r_quo  <= r_sum;
                        r_rem  <= '0;
                        r_div  <= r_eff;
                        r_step <= '0;
                    end
                end
                swmma_pkg::ST_DIV: begin
                    r_quo  <= {r_quo[SUM_W-2:0], div_ge};
                    r_rem  <= div_rem;
                    r_step <= r_step + 1'b1;
                end
                swmma_pkg::ST_POST: begin
                    if (!r_is_read) begin
                        r_mean <= r_quo[SW-1:0];
                    end
                end
                swmma_pkg::ST_EMIT: ;
                default: ;
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.latest     <= swmma_pkg::FIELD_W'(r_latest);
            r_out.average    <= swmma_pkg::FIELD_W'(r_mean);
            r_out.maximum    <= swmma_pkg::FIELD_W'(r_max);
            r_out.minimum    <= swmma_pkg::FIELD_W'(r_min);
            r_out.held_count <= swmma_pkg::COUNT_W'(r_fill);
            r_out.read_valid <= r_is_read && r_rd_ok;
            r_out.read_value <= (r_is_read && r_rd_ok) ?
                                swmma_pkg::FIELD_W'(r_rd_data) : '0;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

[rtl/swmma_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module swmma_chk #(
    parameter int WINDOW_MAX = 64
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_req_valid,
    input wire                   i_req_ready,
    input wire                   i_rsp_valid,
    input wire swmma_pkg::t_rsp  i_rsp_data
);

    // One request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (int'(i_rsp_data.held_count) <= WINDOW_MAX))
        else $error("held_count above window limit");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_data.read_valid) |-> (i_rsp_data.read_value == '0))
        else $error("read_value nonzero without read_valid");

    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_data.held_count == '0)) |->
        ((i_rsp_data.maximum == '0) && (i_rsp_data.minimum == '0) &&
         (i_rsp_data.average == '0) && !i_rsp_data.read_valid))
        else $error("empty window reports statistics");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_rsp_data.minimum <= i_rsp_data.maximum) &&
                         (i_rsp_data.average <= i_rsp_data.maximum)))
        else $error("minimum, mean and maximum out of order");

endmodule

bind sliding_window_min_max_average swmma_chk #(
    .WINDOW_MAX (WINDOW_MAX)
) u_swmma_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire
